FILE: hdl/sncf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sncf_pkg: shared types and constants
// per-item plan record, byte slot codes and the fixed message header
// ----------------------------------------------------------------------------
package sncf_pkg;

    // one planned message fragment for one blob byte
    typedef struct packed {
        logic        hdr;     // chunk opens here: header and offset bytes first
        logic        term;    // chunk closes here: terminator last
        logic [13:0] offset;  // blob offset of this byte
        logic [7:0]  data;    // raw blob byte
    } plan_t;

    // slot index within one fragment, header occupies slots 0..10
    localparam logic [3:0] SLOT_HDR_FIRST = 4'd0;
    localparam logic [3:0] SLOT_OFS_LO    = 4'd11;
    localparam logic [3:0] SLOT_OFS_HI    = 4'd12;
    localparam logic [3:0] SLOT_NIB_HI    = 4'd13;
    localparam logic [3:0] SLOT_NIB_LO    = 4'd14;
    localparam logic [3:0] SLOT_TERM      = 4'd15;

    localparam logic [7:0] TERM_BYTE         = 8'hF7;
    localparam logic [7:0] CHUNK_BYTES_RESET = 8'd183;

    function automatic logic [7:0] hdr_byte(input logic [3:0] slot);
        logic [7:0] b;
        case (slot)
            4'd0:    b = 8'hF0;
            4'd1:    b = 8'h21;
            4'd2:    b = 8'h25;
            4'd3:    b = 8'h7E;
            4'd4:    b = 8'h47;
            4'd5:    b = 8'h50;
            4'd6:    b = 8'h2D;
            4'd7:    b = 8'h32;
            4'd8:    b = 8'h12;
            4'd9:    b = 8'h1C;
            4'd10:   b = 8'h40;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: hdl/sncf_planner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sncf_planner: chunk bookkeeping
// tracks blob offset and chunk position, registers one plan per input byte
// ----------------------------------------------------------------------------
module sncf_planner
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          chunk_bytes,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_data,
    input  logic                in_last,
    output logic                plan_valid,
    output sncf_pkg::plan_t     plan,
    input  logic                plan_take
);
    import sncf_pkg::*;

    logic [13:0] offset_reg, offset_next;
    logic [7:0]  pos_reg, pos_next;
    logic        plan_valid_reg, plan_valid_next;
    plan_t       plan_reg;
    logic [7:0]  limit;
    logic [7:0]  pos_inc;
    logic        term;
    logic        accept;

    assign in_ready = !plan_valid_reg || plan_take;
    assign accept   = in_valid && in_ready;

    // zero chunk size behaves as one
    assign limit   = (chunk_bytes == 8'd0) ? 8'd1 : chunk_bytes;
    assign pos_inc = pos_reg + 8'd1;
    assign term    = (pos_inc >= limit) || in_last;

    always_comb
    begin
        offset_next     = offset_reg;
        pos_next        = pos_reg;
        plan_valid_next = plan_valid_reg && !plan_take;
        if (accept)
        begin
            plan_valid_next = 1'b1;
            offset_next     = in_last ? 14'd0 : (offset_reg + 14'd1);
            pos_next        = term ? 8'd0 : pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            pos_reg        <= '0;
            plan_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg     <= offset_next;
            pos_reg        <= pos_next;
            plan_valid_reg <= plan_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            plan_reg.hdr    <= (pos_reg == 8'd0);
            plan_reg.term   <= term;
            plan_reg.offset <= offset_reg;
            plan_reg.data   <= in_data;
        end
    end

    assign plan_valid = plan_valid_reg;
    assign plan       = plan_reg;

endmodule

FILE: hdl/sncf_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sncf_emitter: byte sequencer
// walks the slots of one plan and, while out_ready allows, drives one output byte per cycle
// ----------------------------------------------------------------------------
module sncf_emitter
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                plan_valid,
    input  sncf_pkg::plan_t     plan,
    output logic                plan_take,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_end,
    output logic                out_last
);
    import sncf_pkg::*;

    logic       busy_reg;
    logic [3:0] slot_reg;
    plan_t      cur_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_end_reg;
    logic       out_last_reg;
    logic       adv;
    logic       cur_last;
    logic [7:0] byte_next;

    assign adv       = !out_valid_reg || out_ready;
    assign cur_last  = (slot_reg == SLOT_TERM) || ((slot_reg == SLOT_NIB_LO) && !cur_reg.term);
    assign plan_take = plan_valid && (!busy_reg || (adv && cur_last));

    always_comb
    begin
        case (slot_reg)
            SLOT_OFS_LO: byte_next = {1'b0, cur_reg.offset[6:0]};
            SLOT_OFS_HI: byte_next = {1'b0, cur_reg.offset[13:7]};
            SLOT_NIB_HI: byte_next = {4'h0, cur_reg.data[7:4]};
            SLOT_NIB_LO: byte_next = {4'h0, cur_reg.data[3:0]};
            SLOT_TERM:   byte_next = TERM_BYTE;
            default:     byte_next = hdr_byte(slot_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                out_valid_reg <= busy_reg;
            if (plan_take)
            begin
                busy_reg <= 1'b1;
                // mid-chunk bytes skip header and offset
                slot_reg <= plan.hdr ? SLOT_HDR_FIRST : SLOT_NIB_HI;
            end
            else if (adv && busy_reg)
            begin
                if (cur_last)
                    busy_reg <= 1'b0;
                else
                    slot_reg <= slot_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (plan_take)
            cur_reg <= plan;
        if (adv && busy_reg)
        begin
            out_byte_reg <= byte_next;
            out_end_reg  <= (slot_reg == SLOT_TERM);
            out_last_reg <= cur_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_end   = out_end_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: hdl/sysex_nibble_chunk_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sysex_nibble_chunk_framer: blob to 7-bit-safe sysex message stream
// every blob byte becomes two nibble bytes, wrapped in header, offset and
// terminator bytes at chunk boundaries
// ----------------------------------------------------------------------------
// path: a request passes the plan register, the emitter's slot and plan registers and the
//   output register before its first output byte appears
// throughput: one output byte per cycle while m_axis_tready allows it; an item yields 2 to 16
//   bytes (2 plain, +13 when it opens a chunk, +1 when it closes one), paced by the output byte sequencer
// reset: offset and chunk position clear to zero, chunk_bytes returns to 183,
//   both stream sides idle
module sysex_nibble_chunk_framer
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration: chunk_bytes
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // last_of_blob
    // output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] message_end
    output logic       m_axis_tlast    // last_of_run
);
    import sncf_pkg::*;

    logic [7:0] chunk_bytes_reg;
    logic       plan_valid;
    plan_t      plan;
    logic       plan_take;

    // chunk size register, compared against the running position at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chunk_bytes_reg <= CHUNK_BYTES_RESET;
        else if (cfg_wr_en)
            chunk_bytes_reg <= cfg_wr_data;
    end

    // stage 1: per-request chunk bookkeeping into a one-entry plan register
    sncf_planner u_planner
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .chunk_bytes (chunk_bytes_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_data     (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .plan_valid  (plan_valid),
        .plan        (plan),
        .plan_take   (plan_take)
    );

    // stage 2: sequencer expands the plan into bytes behind an output register
    sncf_emitter u_emitter
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan_valid (plan_valid),
        .plan       (plan),
        .plan_take  (plan_take),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_end    (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule

FILE: verif/tb_sysex_nibble_chunk_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sysex_nibble_chunk_framer: self-checking bench for the sysex chunk framer
// drives blob bytes through the input stream under varied idle and stall
// patterns, predicts the framed byte stream in a scoreboard and compares
// every output byte field by field in order
// ----------------------------------------------------------------------------
module tb_sysex_nibble_chunk_framer;

    import sncf_pkg::*;

    // clock period is 10 ns; CYCLE_LIMIT is a generous ceiling for the
    // run even with the longest stalls
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int RESET_CYCLES = 6;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_MAX   = 10;

    // fixed message header, first byte in the top bits
    localparam logic [87:0] SYSEX_HDR = 88'hF0_21_25_7E_47_50_2D_32_12_1C_40;
    localparam int          HDR_LEN   = 11;

    // one framed output byte as seen on the master side
    typedef struct packed {
        logic       last_of_run;
        logic       message_end;
        logic [7:0] out_byte;
    } frame_byte_t;

    // ------------------------------------------------------------------------
    // scoreboard: framing predictor plus the queue of bytes still owed
    // ------------------------------------------------------------------------
    class sysex_scoreboard;
        frame_byte_t frame_bytes_due[$];
        logic [13:0] blob_ofs;
        logic [7:0]  chunk_pos;
        logic [7:0]  chunk_size;
        int          mismatches;

        function new();
            blob_ofs   = '0;
            chunk_pos  = '0;
            chunk_size = CHUNK_BYTES_RESET;
            mismatches = 0;
        endfunction

        function void set_chunk_size(logic [7:0] v);
            chunk_size = v;
        endfunction

        function void push_byte(logic [7:0] b, logic term);
            frame_byte_t fb;
            fb.out_byte    = b;
            fb.message_end = term;
            fb.last_of_run = 1'b0;
            frame_bytes_due.insert(frame_bytes_due.size(), fb);
        endfunction

        // expand one accepted blob byte into its framed output bytes
        function void note_request(logic [7:0] d, logic last_of_blob);
            logic [7:0] eff_size;
            frame_byte_t fb;
            int          tail;
            eff_size = (chunk_size == 8'd0) ? 8'd1 : chunk_size;
            if (chunk_pos == 8'd0)
            begin
                for (int i = 0; i < HDR_LEN; i++)
                    push_byte(SYSEX_HDR[87 - 8 * i -: 8], 1'b0);
                push_byte({1'b0, blob_ofs[6:0]}, 1'b0);
                push_byte({1'b0, blob_ofs[13:7]}, 1'b0);
            end
            push_byte({4'h0, d[7:4]}, 1'b0);
            push_byte({4'h0, d[3:0]}, 1'b0);
            blob_ofs  = blob_ofs + 14'd1;
            chunk_pos = chunk_pos + 8'd1;
            if (chunk_pos >= eff_size || last_of_blob)
            begin
                push_byte(TERM_BYTE, 1'b1);
                chunk_pos = '0;
            end
            if (last_of_blob)
                blob_ofs = '0;
            // mark the final byte of this request
            tail = frame_bytes_due.size() - 1;
            fb = frame_bytes_due[tail];
            fb.last_of_run = 1'b1;
            frame_bytes_due[tail] = fb;
        endfunction

        function void check_result(logic [7:0] b, logic term, logic run_end);
            frame_byte_t fb;
            if (frame_bytes_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected output byte %02h end=%0b last=%0b", b, term, run_end);
                return;
            end
            fb = frame_bytes_due.pop_front();
            if (fb.out_byte !== b || fb.message_end !== term || fb.last_of_run !== run_end)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"byte mismatch: expected %02h end=%0b last=%0b, ",
                              "got %02h end=%0b last=%0b"},
                             fb.out_byte, fb.message_end, fb.last_of_run, b, term, run_end);
            end
        endfunction

        function int pending();
            return frame_bytes_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // dut signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       cfg_wr_en     = 1'b0;
    logic [7:0] cfg_wr_data   = 8'h00;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] data_byte
    logic       s_axis_tlast  = 1'b0;   // last_of_blob
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tuser;           // [0] message_end
    logic       m_axis_tlast;           // last_of_run

    sysex_scoreboard sb = new();

    // idle controls shared by the driver task and the sink process
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_off_req   = 0;   // main flow asks for a long sink hold-off here
    int hold_off_left  = 0;   // counted down by the sink process only
    int cycle_count    = 0;

    sysex_nibble_chunk_framer uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // sink side: random stalls, plus a long hold-off on request so the
    // framer backs up and drops s_axis_tready
    always @(posedge clk)
    begin
        if (hold_off_req != 0)
        begin
            hold_off_left = hold_off_req;
            hold_off_req  = 0;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // monitors sample pre-edge values, so they see what the dut saw
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tdata, s_axis_tlast);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // ------------------------------------------------------------------------
    // driver tasks: each returns in the time step of a rising edge
    // ------------------------------------------------------------------------

    // offer one blob byte, with optional random gaps first, and hold it
    // until the framer takes it
    task automatic send_byte(input logic [7:0] d, input logic last_of_blob);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= last_of_blob;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // stop offering and wait until every owed byte is out, then let the
    // pipeline settle so the framer is idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // chunk_bytes write, only called while the framer is idle
    task automatic write_chunk_bytes(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        sb.set_chunk_size(v);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    // random blobs: mostly short blobs so chunk and blob ends hit often
    task automatic blob_traffic(input int n_items, input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < n_items; i++)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // --- directed part --------------------------------------------------
        // chunk_bytes at its reset value, short blob with extreme data
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
        drain();

        // zero chunk size behaves as one: every byte is its own message,
        // the last one closing chunk and blob together
        write_chunk_bytes(8'd0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b1);
        drain();

        write_chunk_bytes(8'd1);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b1);
        drain();

        // chunk of two, blob left open across the register change
        write_chunk_bytes(8'd2);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'h9A, 1'b0);
        drain();

        // grow the chunk mid-message, then shrink it below the position so
        // the next byte closes the chunk at once
        write_chunk_bytes(8'd255);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        drain();
        write_chunk_bytes(8'd2);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b1);
        drain();

        // single-byte blob with the largest chunk size
        write_chunk_bytes(8'd255);
        send_byte(8'hEE, 1'b1);
        drain();

        // --- random part, one idle pattern per phase ------------------------
        write_chunk_bytes(8'($urandom_range(1, 6)));
        blob_traffic(60, 0, 0);
        drain();

        write_chunk_bytes(8'd0);
        blob_traffic(80, 47, 0);
        drain();

        write_chunk_bytes(8'd255);
        blob_traffic(80, 0, 47);
        drain();

        write_chunk_bytes(8'($urandom_range(1, 12)));
        blob_traffic(80, 6, 6);
        drain();

        // back pressure: sink holds off for a long stretch while the sender
        // keeps offering, then the sender pauses until everything is out
        write_chunk_bytes(8'($urandom_range(0, 255)));
        hold_off_req = 300;
        blob_traffic(60, 0, 0);
        drain();
        blob_traffic(30, 47, 47);
        drain();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
